// ===== design/fdm_pkg.sv =====
// shared constants, types and the quarter-wave sine table for the flanger
// no dependencies; imported by every module of the block
package fdm_pkg;

    localparam int LINE_DEPTH   = 1024;
    localparam int SINE_ENTRIES = 256;

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int SINE_W = $clog2(SINE_ENTRIES);

    localparam int SAMPLE_W = 16;
    localparam int A_W      = 32;
    localparam int B_W      = 18;
    localparam int ACC_W    = A_W + B_W;

    // configuration register indexes
    localparam logic [7:0] CFG_MIX   = 8'd0;
    localparam logic [7:0] CFG_BASE  = 8'd1;
    localparam logic [7:0] CFG_DEPTH = 8'd2;
    localparam logic [7:0] CFG_STEP  = 8'd3;

    localparam logic [15:0] MIX_RESET   = 16'd16384;
    localparam logic [8:0]  BASE_RESET  = 9'd125;
    localparam logic [15:0] DEPTH_RESET = 16'd32768;
    localparam logic [23:0] STEP_RESET  = 24'd9739;

    // one in Q15
    localparam logic [15:0] Q15_ONE = 16'd32768;

    // one in Q30, the offset of the delay modulation
    localparam logic signed [ACC_W-1:0] MOD_BIAS = ACC_W'(1) << 30;

    typedef enum logic [1:0]
    {
        ADD_ZERO = 2'd0,
        ADD_BIAS = 2'd1,
        ADD_ACC  = 2'd2
    } add_sel_t;

    typedef struct packed
    {
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        add_sel_t              add_sel;
    } mac_cmd_t;

    typedef logic [14:0] sine_rom_t [SINE_ENTRIES];

    // polynomial quarter sine in Q1.15, evaluated at elaboration
    function automatic logic [14:0] quarter_val(input int unsigned i);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] inner;
        logic [63:0] m;
        logic [63:0] r;
        t     = (64'(i) << 16) / SINE_ENTRIES;
        t2    = (t * t) >> 16;
        inner = 64'd42334 - ((64'd4926 * t2) >> 16);
        m     = 64'd102944 - ((inner * t2) >> 16);
        r     = ((m * t) >> 16) >> 1;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return r[14:0];
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t rom;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            rom[i] = quarter_val(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM  = build_sine();
    // value at the quarter point, one past the table
    localparam logic [14:0] SINE_PEAK = quarter_val(SINE_ENTRIES);

endpackage

// ===== design/flanger_delay_mix.sv =====
// flanger top level: sequencer, configuration registers, sine lfo and output register
// depends on fdm_pkg, fdm_mac and fdm_line
//
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata[15:0] sample_in
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata[15:0] sample_out
// cfg       in         cfg_valid/cfg_ready           cfg_addr index, cfg_data value
//
// each sample is accepted, then makes four passes through the single
// shared multiplier (modulation, delay, dry term, wet term)
// the result lands in an output register; the next sample is taken while it waits
// the last step holds while the output register is still full and not taken
// reset is asynchronous; the delay line needs no clearing pass, a fill mark
// makes unwritten entries read as zero
module flanger_delay_mix
    import fdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_addr,
    input  logic [23:0] cfg_data
);

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_MOD  = 5'b00010,
        ST_DLY  = 5'b00100,
        ST_RD   = 5'b01000,
        ST_WET  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [15:0] mix_reg;
    logic [8:0]  base_reg;
    logic [15:0] depth_reg;
    logic [23:0] step_reg;

    logic [ADDR_W-1:0]   wp_reg;
    logic [ADDR_W-1:0]   wp_next;
    logic [31:0]         phase_reg;
    logic [31:0]         phase_next;
    logic [SAMPLE_W-1:0] cur_reg;
    logic signed [15:0]  sine_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [15:0]         out_data_reg;

    logic                    accept;
    logic                    out_free;
    logic                    finish;
    logic [15:0]             mix_sat;
    logic [15:0]             depth_sat;
    logic [SINE_W+1:0]       lfo_idx;
    logic [1:0]              quad;
    logic [SINE_W-1:0]       off;
    logic [SINE_W-1:0]       off_mirror;
    logic [14:0]             mag;
    logic signed [15:0]      sine_val;
    logic [ADDR_W-1:0]       dly;
    logic [ADDR_W-1:0]       rd_addr;
    logic [SAMPLE_W-1:0]     del;
    logic                    mac_en;
    mac_cmd_t                mac_cmd;
    logic signed [ACC_W-1:0] mac_acc;
    logic signed [ACC_W-1:0] mac_sum;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~out_valid_reg | m_axis_tready;
    assign finish        = (state_reg == ST_WET) & out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        mix_sat   = (mix_reg > Q15_ONE) ? Q15_ONE : mix_reg;
        depth_sat = (depth_reg > Q15_ONE) ? Q15_ONE : depth_reg;
    end

    // sine from the top phase bits, quadrants mirror and negate the quarter table
    always_comb
    begin
        lfo_idx    = phase_reg[31 -: SINE_W + 2];
        quad       = lfo_idx[SINE_W+1:SINE_W];
        off        = lfo_idx[SINE_W-1:0];
        off_mirror = SINE_W'(~off + 1'b1);
        if (quad[0])
        begin
            mag = (off == '0) ? SINE_PEAK : SINE_ROM[off_mirror];
        end
        else
        begin
            mag = SINE_ROM[off];
        end
        sine_val = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // delay modulo the line depth, read position behind the write position
    assign dly     = mac_acc[30 +: ADDR_W];
    assign rd_addr = wp_reg - dly;

    always_comb
    begin
        mac_en          = 1'b0;
        mac_cmd.a       = '0;
        mac_cmd.b       = '0;
        mac_cmd.add_sel = ADD_ZERO;
        unique case (state_reg)
            ST_IDLE:
            begin
                mac_en = 1'b0;
            end
            ST_MOD:
            begin
                mac_en          = 1'b1;
                mac_cmd.a       = A_W'(sine_reg);
                mac_cmd.b       = B_W'(depth_sat);
                mac_cmd.add_sel = ADD_BIAS;
            end
            ST_DLY:
            begin
                mac_en    = 1'b1;
                mac_cmd.a = $signed(mac_acc[A_W-1:0]);
                mac_cmd.b = B_W'(base_reg);
            end
            ST_RD:
            begin
                mac_en    = 1'b1;
                mac_cmd.a = A_W'(cur_reg);
                mac_cmd.b = B_W'(Q15_ONE - mix_sat);
            end
            ST_WET:
            begin
                mac_en          = out_free;
                mac_cmd.a       = A_W'(del);
                mac_cmd.b       = B_W'(mix_sat);
                mac_cmd.add_sel = ADD_ACC;
            end
            default:
            begin
                mac_en = 1'b0;
            end
        endcase
    end

    fdm_mac u_mac
    (
        .clk (clk),
        .en  (mac_en),
        .cmd (mac_cmd),
        .acc (mac_acc),
        .sum (mac_sum)
    );

    fdm_line u_line
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (s_axis_tdata),
        .rd_en   (state_reg == ST_RD),
        .rd_addr (rd_addr),
        .rd_data (del)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = accept ? ST_MOD : ST_IDLE;
            ST_MOD:  state_next = ST_DLY;
            ST_DLY:  state_next = ST_RD;
            ST_RD:   state_next = ST_WET;
            ST_WET:  state_next = out_free ? ST_IDLE : ST_WET;
            default: state_next = ST_IDLE;
        endcase

        wp_next        = finish ? wp_reg + 1'b1 : wp_reg;
        phase_next     = finish ? phase_reg + {8'd0, step_reg} : phase_reg;
        out_valid_next = finish | (out_valid_reg & ~m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            mix_reg       <= MIX_RESET;
            base_reg      <= BASE_RESET;
            depth_reg     <= DEPTH_RESET;
            step_reg      <= STEP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid & cfg_ready)
            begin
                unique case (cfg_addr)
                    CFG_MIX:   mix_reg   <= cfg_data[15:0];
                    CFG_BASE:  base_reg  <= cfg_data[8:0];
                    CFG_DEPTH: depth_reg <= cfg_data[15:0];
                    CFG_STEP:  step_reg  <= cfg_data;
                    default:   mix_reg   <= mix_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg  <= s_axis_tdata;
            sine_reg <= sine_val;
        end
        if (finish)
        begin
            out_data_reg <= mac_sum[30:15];
        end
    end

endmodule

// ===== design/fdm_mac.sv =====
// shared multiply-accumulate unit of the flanger sequencer
// depends on fdm_pkg for operand widths and the command struct
module fdm_mac
    import fdm_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  mac_cmd_t                cmd,
    output logic signed [ACC_W-1:0] acc,
    output logic signed [ACC_W-1:0] sum
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] addend;

    always_comb
    begin
        prod = $signed(cmd.a) * $signed(cmd.b);
        unique case (cmd.add_sel)
            ADD_ZERO: addend = '0;
            ADD_BIAS: addend = MOD_BIAS;
            ADD_ACC:  addend = acc_reg;
            default:  addend = '0;
        endcase
        sum = addend + prod;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= sum;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== design/fdm_line.sv =====
// ring delay line memory with registered read
// depends on fdm_pkg; unwritten entries read as zero through a fill mark
module fdm_line
    import fdm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(LINE_DEPTH - 1);

    logic [SAMPLE_W-1:0] mem [LINE_DEPTH];
    logic [SAMPLE_W-1:0] q_reg;
    logic                wrap_reg;
    logic                wrap_next;
    logic                hit_reg;
    logic                hit_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // writes run in order from zero, so below the write mark all entries are filled
    always_comb
    begin
        wrap_next = wrap_reg | (wr_en & (wr_addr == ADDR_LAST));
        hit_next  = rd_en ? (wrap_reg | (rd_addr <= wr_addr)) : hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            wrap_reg <= wrap_next;
            hit_reg  <= hit_next;
        end
    end

    assign rd_data = hit_reg ? q_reg : '0;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for flanger_delay_mix: random and directed samples under config sweeps
// keeps its own flanger predictor and scoreboard; depends on fdm_pkg and the design sources
module tb;
    import fdm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN    = 400;
    localparam int RAND_PHASES = 26;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] sample_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] sample_out
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_addr;
    logic [23:0] cfg_data;

    // predictor state and register copies
    logic [15:0]       delay_mem [LINE_DEPTH];
    logic [ADDR_W-1:0] wr_ptr;
    logic [31:0]       lfo_acc;
    logic [15:0]       mix_reg;
    logic [8:0]        base_reg;
    logic [15:0]       depth_reg;
    logic [23:0]       step_reg;

    logic [15:0] dry_samples[$];
    logic [15:0] mixed_expect[$];
    logic [15:0] want_sample;

    int          burst_left;
    int          gap_left;
    int          send_gap_max = 2;
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [3:0]  stall_tick;
    logic        hold_start = 1'b0;
    int          hold_cycles;
    int          fail_count = 0;
    int          cycle_count = 0;

    flanger_delay_mix DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // polynomial quarter sine in Q1.15 at table point i
    function automatic int quarter_sine_q15(input int unsigned i);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned poly;
        longint unsigned r;
        t    = (longint'(i) << 16) / SINE_ENTRIES;
        t2   = (t * t) >> 16;
        poly = 102944 - (((42334 - ((4926 * t2) >> 16)) * t2) >> 16);
        r    = ((poly * t) >> 16) >> 1;
        return (r > 32767) ? 32767 : int'(r);
    endfunction

    function automatic int lfo_sine_q15(input logic [31:0] phase);
        logic [SINE_W+1:0] idx;
        int                mag;
        idx = phase[31 -: SINE_W + 2];
        if (idx[SINE_W])
        begin
            mag = quarter_sine_q15(SINE_ENTRIES - int'(idx[SINE_W-1:0]));
        end
        else
        begin
            mag = quarter_sine_q15(32'(idx[SINE_W-1:0]));
        end
        return idx[SINE_W+1] ? -mag : mag;
    endfunction

    // one flanger step: store the dry sample, read the modulated tap, blend
    function automatic logic [15:0] flange_sample(input logic [15:0] dry);
        longint            mix_sat;
        longint            depth_sat;
        longint            mod_q30;
        longint            dly;
        logic [ADDR_W-1:0] rd_ptr;
        logic [15:0]       wet;
        longint unsigned   acc;
        mix_sat   = (mix_reg > Q15_ONE) ? 32768 : longint'(mix_reg);
        depth_sat = (depth_reg > Q15_ONE) ? 32768 : longint'(depth_reg);
        mod_q30   = (longint'(1) << 30) + depth_sat * longint'(lfo_sine_q15(lfo_acc));
        dly       = (longint'(base_reg) * mod_q30) >> 30;
        delay_mem[wr_ptr] = dry;
        rd_ptr    = wr_ptr - ADDR_W'(dly);
        wet       = delay_mem[rd_ptr];
        acc       = (32768 - mix_sat) * longint'(dry) + mix_sat * longint'(wet);
        wr_ptr    = wr_ptr + 1'b1;
        lfo_acc   = lfo_acc + 32'(step_reg);
        return acc[30:15];
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                mixed_expect.push_back(flange_sample(s_axis_tdata));
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (dry_samples.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= dry_samples.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= $urandom_range(0, send_gap_max);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
        end
        else if (hold_start)
        begin
            hold_cycles <= HOLD_LEN;
        end
        else if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // receiver: stall pattern plus result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_tick    <= '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (mixed_expect.size() == 0)
                begin
                    $error("sample_out: expected none, got 0x%04h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want_sample = mixed_expect.pop_front();
                    if (m_axis_tdata !== want_sample)
                    begin
                        $error("sample_out: expected 0x%04h, got 0x%04h",
                               want_sample, m_axis_tdata);
                        fail_count++;
                    end
                end
            end
            stall_tick    <= stall_tick + 1'b1;
            m_axis_tready <= (hold_cycles == 0) && ready_pattern[stall_tick];
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // called just after a rising edge; returns once the write is taken and cfg_valid is dropped
    task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MIX:   mix_reg   = val[15:0];
            CFG_BASE:  base_reg  = val[8:0];
            CFG_DEPTH: depth_reg = val[15:0];
            CFG_STEP:  step_reg  = val[23:0];
            default:   ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_quiet();
        while (dry_samples.size() != 0 || s_axis_tvalid || mixed_expect.size() != 0 ||
               hold_cycles != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [23:0] pick_q15();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'(Q15_ONE);
            2:       return {8'($urandom), 16'hFFFF};
            3:       return 24'($urandom);
            default: return 24'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic pick_config();
        write_reg(CFG_MIX, pick_q15());
        case ($urandom_range(0, 3))
            0:       write_reg(CFG_BASE, 24'd0);
            1:       write_reg(CFG_BASE, 24'd511);
            2:       write_reg(CFG_BASE, 24'($urandom));
            default: write_reg(CFG_BASE, 24'($urandom_range(0, 511)));
        endcase
        write_reg(CFG_DEPTH, pick_q15());
        case ($urandom_range(0, 4))
            0:       write_reg(CFG_STEP, 24'd0);
            1:       write_reg(CFG_STEP, 24'hFFFFFF);
            2:       write_reg(CFG_STEP, 24'($urandom_range(0, 20000)));
            default: write_reg(CFG_STEP, 24'($urandom));
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(8'($urandom_range(int'(CFG_STEP) + 1, 255)), 24'($urandom));
        end
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        foreach (delay_mem[i])
        begin
            delay_mem[i] = '0;
        end
        wr_ptr    = '0;
        lfo_acc   = '0;
        mix_reg   = MIX_RESET;
        base_reg  = BASE_RESET;
        depth_reg = DEPTH_RESET;
        step_reg  = STEP_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        dry_samples = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
        wait_quiet();

        // dry only, no delay, frozen lfo
        write_reg(CFG_MIX, 24'd0);
        write_reg(CFG_BASE, 24'd0);
        write_reg(CFG_DEPTH, 24'd0);
        write_reg(CFG_STEP, 24'd0);
        dry_samples = '{16'hFFFF, 16'h0000, 16'h5555};
        wait_quiet();

        // fully wet, longest delay, depth saturating, fastest sweep with phase wrap
        write_reg(CFG_MIX, 24'(Q15_ONE));
        write_reg(CFG_BASE, 24'd511);
        write_reg(CFG_DEPTH, 24'h00FFFF);
        write_reg(CFG_STEP, 24'hFFFFFF);
        dry_samples = '{16'hAAAA, 16'hFFFF, 16'h0001, 16'h8000};
        wait_quiet();

        // mix saturating, upper data bits masked off, one 1024th of a turn per sample
        write_reg(CFG_MIX, 24'hFFFFFF);
        write_reg(CFG_BASE, 24'hFFFFFF);
        write_reg(CFG_DEPTH, 24'(Q15_ONE));
        write_reg(CFG_STEP, 24'h400000);
        dry_samples = '{16'h1234, 16'hFEDC, 16'h0000, 16'hFFFF};
        wait_quiet();

        // writes to unused indexes leave everything alone
        write_reg(8'(int'(CFG_STEP) + 1), 24'($urandom));
        write_reg(8'hFF, 24'hFFFFFF);
        dry_samples = '{16'hFFFF, 16'h0000};
        wait_quiet();

        write_reg(CFG_MIX, 24'd1);
        write_reg(CFG_BASE, 24'd1);
        write_reg(CFG_DEPTH, 24'd1);
        write_reg(CFG_STEP, 24'($urandom));
        dry_samples = '{16'h7FFF, 16'h8001, 16'hC3C3};
        wait_quiet();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            pick_config();
            if (p == RAND_PHASES / 3)
            begin
                // receiver holds off while the sender keeps pushing
                ready_pattern = 16'hFFFF;
                send_gap_max  = 0;
                hold_start   <= 1'b1;
                @(posedge clk);
                hold_start   <= 1'b0;
                repeat (30) dry_samples.push_back(pick_sample());
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'h0101;
                    default: ready_pattern = 16'($urandom) | 16'h0001;
                endcase
                case ($urandom_range(0, 3))
                    0:       send_gap_max = 0;
                    1:       send_gap_max = 9;
                    default: send_gap_max = 3;
                endcase
                repeat ($urandom_range(15, 35)) dry_samples.push_back(pick_sample());
            end
            wait_quiet();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fdm_pkg.sv
design/fdm_mac.sv
design/fdm_line.sv
design/flanger_delay_mix.sv
dv/tb.sv
